FILE: src/rlct_pkg.sv
// rlct_pkg: shared types, gamma and cube-root tables, threshold windows.
// Depends on nothing; imported by rlct_lab_core and rgb565_lab_color_threshold.
package rlct_pkg;

    typedef struct packed {
        logic [9:0] x;
        logic [9:0] y;
        logic [9:0] z;
    } xyz_t;

    typedef struct packed {
        logic signed [8:0] chroma_b;
        logic signed [9:0] chroma_a;
        logic [7:0]        lum;
    } lab_t;

    typedef logic [9:0] gamma5_rom_t [32];
    typedef logic [9:0] gamma6_rom_t [64];
    typedef logic [9:0] cbrt_rom_t [1024];

    // floor(1024 * srgb_to_linear(c)), 5-bit and 6-bit codes
    localparam gamma5_rom_t GAMMA5 = '{
        10'd0,   10'd2,   10'd5,   10'd9,   10'd14,  10'd21,  10'd30,  10'd40,
        10'd52,  10'd65,  10'd81,  10'd99,  10'd118, 10'd140, 10'd164, 10'd190,
        10'd219, 10'd249, 10'd283, 10'd318, 10'd356, 10'd397, 10'd440, 10'd486,
        10'd535, 10'd586, 10'd640, 10'd696, 10'd756, 10'd819, 10'd884, 10'd952
    };

    localparam gamma6_rom_t GAMMA6 = '{
        10'd0,   10'd1,   10'd2,   10'd3,   10'd5,   10'd7,   10'd9,   10'd11,
        10'd14,  10'd17,  10'd21,  10'd25,  10'd30,  10'd34,  10'd40,  10'd45,
        10'd52,  10'd58,  10'd65,  10'd73,  10'd81,  10'd90,  10'd99,  10'd108,
        10'd118, 10'd129, 10'd140, 10'd152, 10'd164, 10'd177, 10'd190, 10'd204,
        10'd219, 10'd234, 10'd249, 10'd266, 10'd283, 10'd300, 10'd318, 10'd337,
        10'd356, 10'd376, 10'd397, 10'd418, 10'd440, 10'd463, 10'd486, 10'd510,
        10'd535, 10'd560, 10'd586, 10'd612, 10'd640, 10'd668, 10'd696, 10'd726,
        10'd756, 10'd787, 10'd819, 10'd851, 10'd884, 10'd918, 10'd952, 10'd987
    };

    // Linear segment 7.787*i + 141.2 for the darkest codes
    localparam logic [9:0] LOW_SEG [10] = '{
        10'd141, 10'd148, 10'd156, 10'd164, 10'd172,
        10'd180, 10'd187, 10'd195, 10'd203, 10'd211
    };
    localparam int LOW_SEG_LEN = 10;

    // RGB -> XYZ weights, Q20
    localparam logic [29:0] COEF_XR = 30'd455026;
    localparam logic [29:0] COEF_XG = 30'd394489;
    localparam logic [29:0] COEF_XB = 30'd1;
    localparam logic [29:0] COEF_YR = 30'd223002;
    localparam logic [29:0] COEF_YG = 30'd749900;
    localparam logic [29:0] COEF_YB = 30'd75675;
    localparam logic [29:0] COEF_ZR = 30'd18619;
    localparam logic [29:0] COEF_ZG = 30'd114786;
    localparam logic [29:0] COEF_ZB = 30'd915097;

    // Threshold windows, all bounds exclusive
    localparam int NEAR_L_LO = 80;
    localparam int NEAR_L_HI = 100;
    localparam int NEAR_A_LO = -22;
    localparam int NEAR_A_HI = 11;
    localparam int NEAR_B_LO = -10;
    localparam int NEAR_B_HI = 100;
    localparam int FAR_L_LO  = 13;
    localparam int FAR_L_HI  = 60;
    localparam int FAR_A_LO  = 29;
    localparam int FAR_A_HI  = 80;
    localparam int FAR_B_LO  = -128;
    localparam int FAR_B_HI  = 127;

    // Cube-root table, scaled by 1024. Exact cubes land one below the root.
    function automatic cbrt_rom_t build_cbrt();
        cbrt_rom_t    t;
        logic [63:0]  n;
        logic [63:0]  c;
        logic [9:0]   root;
        logic [9:0]   trial;
        for (int i = 0; i < 1024; i++)
        begin
            if (i < LOW_SEG_LEN)
            begin
                t[i] = LOW_SEG[i];
            end
            else
            begin
                n    = 64'(i) << 20;
                root = '0;
                for (int b = 9; b >= 0; b--)
                begin
                    trial = root | (10'd1 << b);
                    c     = 64'(trial) * 64'(trial) * 64'(trial);
                    if (c <= n)
                        root = trial;
                end
                c = 64'(root) * 64'(root) * 64'(root);
                if (c == n)
                    root = root - 10'd1;
                t[i] = root;
            end
        end
        return t;
    endfunction

    function automatic logic in_window_f(lab_t v, logic far);
        int l;
        int a;
        int b;
        l = int'(v.lum);
        a = int'(v.chroma_a);
        b = int'(v.chroma_b);
        if (far)
            return (l > FAR_L_LO) && (l < FAR_L_HI) && (a > FAR_A_LO) && (a < FAR_A_HI)
                && (b > FAR_B_LO) && (b < FAR_B_HI);
        else
            return (l > NEAR_L_LO) && (l < NEAR_L_HI) && (a > NEAR_A_LO)
                && (a < NEAR_A_HI) && (b > NEAR_B_LO) && (b < NEAR_B_HI);
    endfunction

endpackage

FILE: src/rlct_lab_core.sv
// rlct_lab_core: XYZ -> L*a*b*, two stages (cube-root ROM read, L/a/b math).
// Depends on rlct_pkg.
module rlct_lab_core
    import rlct_pkg::*;
(
    input  logic       clk,
    input  logic [1:0] stage_en,   // [0] ROM stage, [1] math stage
    input  xyz_t       xyz,
    output lab_t       lab
);

    localparam cbrt_rom_t CUBE_ROM = build_cbrt();
    localparam logic [9:0] DARK_Y_MAX = 10'd9;

    logic [9:0]  fx_reg;
    logic [9:0]  fy_reg;
    logic [9:0]  fz_reg;
    logic        dark_reg;
    lab_t        lab_reg;
    lab_t        lab_next;

    logic signed [10:0] d_xy;
    logic signed [10:0] d_yz;
    logic signed [20:0] l_prod;
    logic signed [20:0] a_prod;
    logic signed [20:0] b_prod;
    logic signed [20:0] fy_s;

    // Three ROM copies, registered read
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            fx_reg   <= CUBE_ROM[xyz.x];
            fy_reg   <= CUBE_ROM[xyz.y];
            fz_reg   <= CUBE_ROM[xyz.z];
            dark_reg <= (xyz.y <= DARK_Y_MAX);
        end
    end

    always_comb
    begin
        fy_s   = 21'($signed({1'b0, fy_reg}));
        d_xy   = $signed({1'b0, fx_reg}) - $signed({1'b0, fy_reg});
        d_yz   = $signed({1'b0, fy_reg}) - $signed({1'b0, fz_reg});
        if (dark_reg)
            l_prod = fy_s * 21'sd903;
        else
            l_prod = fy_s * 21'sd116 - 21'sd16384;
        a_prod = 21'(d_xy) * 21'sd500;
        b_prod = 21'(d_yz) * 21'sd200;
        // arithmetic shift floors toward minus infinity
        lab_next.lum      = 8'(l_prod >>> 10);
        lab_next.chroma_a = 10'(a_prod >>> 10);
        lab_next.chroma_b = 9'(b_prod >>> 10);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
            lab_reg <= lab_next;
    end

    assign lab = lab_reg;

endmodule

FILE: src/rgb565_lab_color_threshold.sv
// rgb565_lab_color_threshold: top level, RGB565 -> L*a*b* with window threshold.
// Depends on rlct_pkg and rlct_lab_core.
//
// Takes one RGB565 pixel per transfer and returns one result per pixel: L, a,
// b and a flag set when all three lie strictly inside the near or far window
// (picked by the far_mode register, written on the cfg channel; reset = near).
// Throughput is one pixel per clock while the output is not stalled. The
// six-stage pipeline registers each step in order: gamma ROMs, XYZ products,
// XYZ sums, cube-root ROM read, L/a/b math, window compare. Each stage has its
// own valid bit and advances when it is empty or the stage after it moves, so
// bubbles collapse and a stalled output does not block input until the whole
// pipeline is full. far_mode should change only while no pixel is in flight.
module rgb565_lab_color_threshold
    import rlct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pixel_rgb565 (R 15:11, G 10:5, B 4:0)
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] lum, [17:8] chroma_a, [26:18] chroma_b, rest 0
    output logic        m_axis_tuser,   // [0] in_window
    // config
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data        // far_mode
);

    localparam int NSTAGE = 6;

    logic [NSTAGE:1] v_reg;
    logic [NSTAGE:1] v_next;
    logic [NSTAGE:1] en;
    logic            far_mode_reg;

    // stage 1: linearized channels
    logic [9:0] lr_reg;
    logic [9:0] lg_reg;
    logic [9:0] lb_reg;
    // stage 2: weighted terms
    logic [29:0] p_reg [9];
    // stage 3: XYZ
    xyz_t xyz_reg;
    xyz_t xyz_next;
    logic [30:0] sum_x;
    logic [30:0] sum_y;
    logic [30:0] sum_z;
    // stage 5 out of the core, stage 6 here
    lab_t lab5;
    lab_t lab_reg;
    logic hit_reg;

    // Per-stage advance: a stage moves when empty or when its successor moves
    always_comb
    begin
        en[NSTAGE] = !v_reg[NSTAGE] || m_axis_tready;
        for (int k = NSTAGE - 1; k >= 1; k--)
            en[k] = !v_reg[k] || en[k + 1];
        v_next[1] = en[1] ? s_axis_tvalid : v_reg[1];
        for (int k = 2; k <= NSTAGE; k++)
            v_next[k] = en[k] ? v_reg[k - 1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg        <= '0;
            far_mode_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
            if (cfg_valid && cfg_ready)
                far_mode_reg <= cfg_data;
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = en[1];

    // stage 1: gamma ROMs
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            lr_reg <= GAMMA5[s_axis_tdata[15:11]];
            lg_reg <= GAMMA6[s_axis_tdata[10:5]];
            lb_reg <= GAMMA5[s_axis_tdata[4:0]];
        end
    end

    // stage 2: one multiply per term
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p_reg[0] <= 30'(lr_reg) * COEF_XR;
            p_reg[1] <= 30'(lg_reg) * COEF_XG;
            p_reg[2] <= 30'(lb_reg) * COEF_XB;
            p_reg[3] <= 30'(lr_reg) * COEF_YR;
            p_reg[4] <= 30'(lg_reg) * COEF_YG;
            p_reg[5] <= 30'(lb_reg) * COEF_YB;
            p_reg[6] <= 30'(lr_reg) * COEF_ZR;
            p_reg[7] <= 30'(lg_reg) * COEF_ZG;
            p_reg[8] <= 30'(lb_reg) * COEF_ZB;
        end
    end

    // stage 3: sums, >> 20 (all sums stay below 2^30)
    always_comb
    begin
        sum_x = 31'(p_reg[0]) + 31'(p_reg[1]) + 31'(p_reg[2]);
        sum_y = 31'(p_reg[3]) + 31'(p_reg[4]) + 31'(p_reg[5]);
        sum_z = 31'(p_reg[6]) + 31'(p_reg[7]) + 31'(p_reg[8]);
        xyz_next.x = sum_x[29:20];
        xyz_next.y = sum_y[29:20];
        xyz_next.z = sum_z[29:20];
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
            xyz_reg <= xyz_next;
    end

    // stages 4 and 5
    rlct_lab_core u_lab_core
    (
        .clk      (clk),
        .stage_en (en[5:4]),
        .xyz      (xyz_reg),
        .lab      (lab5)
    );

    // stage 6: window compare, output register
    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            lab_reg <= lab5;
            hit_reg <= in_window_f(lab5, far_mode_reg);
        end
    end

    assign m_axis_tvalid = v_reg[NSTAGE];
    assign m_axis_tdata  = {5'd0, lab_reg.chroma_b, lab_reg.chroma_a, lab_reg.lum};
    assign m_axis_tuser  = hit_reg;

    // An empty output stage means every stage can move, so input is open
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // An input transfer always lands in stage 1
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v_reg[1])
        else $error("accepted pixel lost at stage 1");

    // A marked pixel has L strictly between the far low bound and the near high bound
    a_hit_lum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[7:0] > 8'd13) && (m_axis_tdata[7:0] < 8'd100))
        else $error("in_window set with L outside both windows");

    // L never exceeds the dark-segment maximum
    a_lum_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] <= 8'd186)
        else $error("L out of range");

endmodule

FILE: tb/rgb565_lab_color_threshold_test.sv
// rgb565_lab_color_threshold_test: self-checking bench for the RGB565 -> L*a*b* thresholder.
// Depends on rlct_pkg (lab_t) and the rgb565_lab_color_threshold RTL; needs nothing else.
// Directed probe table first, then random pixels under three idle profiles and one long stall.
module rgb565_lab_color_threshold_test
    import rlct_pkg::*;
();

    // One expected output transfer, tagged with the pixel that caused it
    typedef struct packed {
        logic [15:0] pixel;
        lab_t        lab;
        logic        in_window;
    } pixel_lab_t;

    // Directed probe: mode to run in, pixel, and optionally a hand-written answer
    typedef struct {
        logic        far;
        logic [15:0] pixel;
        logic        fixed_value;
        lab_t        lab;
        logic        in_window;
    } probe_row_t;

    // floor(1024 * linear(c)) for 5-bit and 6-bit sRGB codes
    localparam int SRGB5_LIN [32] = '{
        0, 2, 5, 9, 14, 21, 30, 40, 52, 65, 81, 99, 118, 140, 164, 190,
        219, 249, 283, 318, 356, 397, 440, 486, 535, 586, 640, 696, 756, 819, 884, 952
    };
    localparam int SRGB6_LIN [64] = '{
        0, 1, 2, 3, 5, 7, 9, 11, 14, 17, 21, 25, 30, 34, 40, 45,
        52, 58, 65, 73, 81, 90, 99, 108, 118, 129, 140, 152, 164, 177, 190, 204,
        219, 234, 249, 266, 283, 300, 318, 337, 356, 376, 397, 418, 440, 463, 486, 510,
        535, 560, 586, 612, 640, 668, 696, 726, 756, 787, 819, 851, 884, 918, 952, 987
    };
    // Linear toe of f(t) for the ten darkest codes
    localparam int DARK_CBRT [10] = '{141, 148, 156, 164, 172, 180, 187, 195, 203, 211};

    // Exclusive bounds: L lo/hi, a lo/hi, b lo/hi
    localparam int NEAR_BOUNDS [6] = '{80, 100, -22, 11, -10, 100};
    localparam int FAR_BOUNDS [6]  = '{13, 60, 29, 80, -128, 127};

    localparam int PROBE_ROWS = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [15:0] pixel_rgb565
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [7:0] lum, [17:8] chroma_a, [26:18] chroma_b
    logic        m_axis_tuser;          // [0] in_window
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;       // far_mode

    pixel_lab_t  expected_lab_q [$];
    logic        far_mode_copy = 1'b0;  // bench's copy of the mode register
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        stall_request = 1'b0;  // main flow asks the receiver for a long hold-off
    int          stall_left = 0;
    int          fail_count = 0;

    // Black reads the same in both modes: L = 903*141 >> 10 = 124, a = b = 0, outside both.
    probe_row_t probe_rows [PROBE_ROWS] = '{
        '{1'b0, 16'h0000, 1'b1, '{9'sd0, 10'sd0, 8'd124}, 1'b0},  // black right after reset
        '{1'b0, 16'hFFFF, 1'b0, '0, 1'b0},                       // white
        '{1'b0, 16'hF800, 1'b0, '0, 1'b0},                       // full red
        '{1'b0, 16'h07E0, 1'b0, '0, 1'b0},                       // full green
        '{1'b0, 16'h001F, 1'b0, '0, 1'b0},                       // full blue
        '{1'b0, 16'h0001, 1'b0, '0, 1'b0},                       // darkest blue, 903 path
        '{1'b0, 16'h3804, 1'b0, '0, 1'b0},                       // Y = 9, last dark code
        '{1'b0, 16'h3805, 1'b0, '0, 1'b0},                       // Y = 10, first cube-root code
        '{1'b0, 16'h2920, 1'b0, '0, 1'b0},                       // Y = 16, exact cube drops one
        '{1'b0, 16'hFF1C, 1'b0, '0, 1'b0},                       // warm white, near window
        '{1'b0, 16'hA14A, 1'b0, '0, 1'b0},                       // dull red, far color in near mode
        '{1'b0, 16'hF81F, 1'b0, '0, 1'b0},                       // magenta
        '{1'b0, 16'h7BEF, 1'b0, '0, 1'b0},                       // mid gray
        '{1'b1, 16'h0000, 1'b1, '{9'sd0, 10'sd0, 8'd124}, 1'b0},  // black, far mode
        '{1'b1, 16'hA14A, 1'b0, '0, 1'b0},                       // dull red, far window
        '{1'b1, 16'hFF1C, 1'b0, '0, 1'b0},
        '{1'b1, 16'hFFFF, 1'b0, '0, 1'b0},
        '{1'b1, 16'hF800, 1'b0, '0, 1'b0},
        '{1'b1, 16'h07E0, 1'b0, '0, 1'b0},
        '{1'b1, 16'h001F, 1'b0, '0, 1'b0}
    };

    rgb565_lab_color_threshold dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // f(t) table entry, scaled by 1024: integer cube root of idx * 2^20,
    // one lower when that product is a perfect cube.
    function automatic int cube_rom_entry(int idx);
        longint unsigned n;
        longint unsigned t;
        int              root;
        idx = idx & 1023;
        if (idx < 10)
            return DARK_CBRT[idx];
        n    = longint'(idx) << 20;
        root = 0;
        for (int step = 512; step > 0; step = step / 2)
        begin
            t = root | step;
            if (t * t * t <= n)
                root = root | step;
        end
        t = root;
        if (t * t * t == n)
            root = root - 1;
        return root;
    endfunction

    function automatic logic inside_bounds(int bounds [6], int l, int a, int b);
        return l > bounds[0] && l < bounds[1] && a > bounds[2] && a < bounds[3]
            && b > bounds[4] && b < bounds[5];
    endfunction

    // Full pixel -> L*a*b* -> window flag prediction. >>> on int floors toward -inf.
    function automatic pixel_lab_t predict_lab(logic [15:0] px, logic far);
        longint     lr;
        longint     lg;
        longint     lb;
        int         x;
        int         y;
        int         z;
        int         fx;
        int         fy;
        int         fz;
        int         l;
        int         a;
        int         b;
        pixel_lab_t res;
        lr = SRGB5_LIN[px[15:11]];
        lg = SRGB6_LIN[px[10:5]];
        lb = SRGB5_LIN[px[4:0]];
        x  = int'((455026 * lr + 394489 * lg + 1 * lb) >> 20);
        y  = int'((223002 * lr + 749900 * lg + 75675 * lb) >> 20);
        z  = int'((18619 * lr + 114786 * lg + 915097 * lb) >> 20);
        fx = cube_rom_entry(x);
        fy = cube_rom_entry(y);
        fz = cube_rom_entry(z);
        if (y > 9)
            l = (116 * fy - 16384) >>> 10;
        else
            l = (903 * fy) >>> 10;
        a = (500 * (fx - fy)) >>> 10;
        b = (200 * (fy - fz)) >>> 10;
        res.pixel          = px;
        res.lab.lum        = l[7:0];
        res.lab.chroma_a   = a[9:0];
        res.lab.chroma_b   = b[8:0];
        res.in_window      = far ? inside_bounds(FAR_BOUNDS, l, a, b)
                                 : inside_bounds(NEAR_BOUNDS, l, a, b);
        return res;
    endfunction

    // Channel value around a base color, clamped to the channel's range
    function automatic int jitter(int base, int span, int top);
        int v;
        v = base + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > top)
            v = top;
        return v;
    endfunction

    // Offer one pixel after a random gap; the expectation is queued at the
    // edge where the transfer happens.
    task automatic send_pixel(input logic [15:0] px, input pixel_lab_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_lab_q.push_back(want);
    endtask

    // Mode changes only with nothing in flight: every pixel yields a result,
    // so an empty queue means the pipeline is empty too.
    task automatic set_far_mode(input logic mode);
        s_axis_tvalid <= 1'b0;
        while (expected_lab_q.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid     <= 1'b0;
        far_mode_copy = mode;
    endtask

    // Uniform noise over the whole 16-bit space for just over half the pixels; the
    // rest are colors around the two window targets and the dark toe.
    task automatic run_random(input int count, input int stall_at);
        logic [15:0] px;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            if (i == stall_at)
                stall_request = 1'b1;
            pick = $urandom_range(99);
            if (pick < 55)
                px = 16'($urandom_range(16'hFFFF));
            else if (pick < 70)
                px = {5'(jitter(31, 3, 31)), 6'(jitter(56, 5, 63)), 5'(jitter(28, 3, 31))};
            else if (pick < 85)
                px = {5'(jitter(20, 4, 31)), 6'(jitter(10, 6, 63)), 5'(jitter(10, 4, 31))};
            else
                px = {5'($urandom_range(7)), 6'($urandom_range(15)), 5'($urandom_range(7))};
            send_pixel(px, predict_lab(px, far_mode_copy));
        end
    endtask

    // Result side: check each output transfer, then pick next cycle's tready.
    always @(posedge clk)
    begin
        pixel_lab_t want;
        lab_t       got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[26:0];
                if (expected_lab_q.size() == 0)
                begin
                    $error("result with nothing pending: tdata %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_lab_q.pop_front();
                    if (got.lum !== want.lab.lum)
                    begin
                        $error("lum (pixel %h): expected %0d, got %0d",
                               want.pixel, want.lab.lum, got.lum);
                        fail_count++;
                    end
                    if (got.chroma_a !== want.lab.chroma_a)
                    begin
                        $error("chroma_a (pixel %h): expected %0d, got %0d",
                               want.pixel, want.lab.chroma_a, got.chroma_a);
                        fail_count++;
                    end
                    if (got.chroma_b !== want.lab.chroma_b)
                    begin
                        $error("chroma_b (pixel %h): expected %0d, got %0d",
                               want.pixel, want.lab.chroma_b, got.chroma_b);
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.in_window)
                    begin
                        $error("in_window (pixel %h): expected %0d, got %0d",
                               want.pixel, want.in_window, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            // Long hold-off: the pipeline fills and s_axis_tready must drop
            if (stall_request)
            begin
                stall_left    = 60;
                stall_request = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        pixel_lab_t want;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed probes; mode is the reset value until a row asks for far
        send_idle_pct = 32;
        recv_idle_pct = 48;
        for (int i = 0; i < PROBE_ROWS; i++)
        begin
            if (probe_rows[i].far != far_mode_copy)
                set_far_mode(probe_rows[i].far);
            if (probe_rows[i].fixed_value)
            begin
                want.pixel     = probe_rows[i].pixel;
                want.lab       = probe_rows[i].lab;
                want.in_window = probe_rows[i].in_window;
            end
            else
            begin
                want = predict_lab(probe_rows[i].pixel, far_mode_copy);
            end
            send_pixel(probe_rows[i].pixel, want);
        end

        // Random: sender lighter idle than receiver, near window
        set_far_mode(1'b0);
        run_random(300, -1);

        // Roles swapped, far window
        send_idle_pct = 48;
        recv_idle_pct = 32;
        set_far_mode(1'b1);
        run_random(300, -1);

        // Back to back with one long receiver stall
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_far_mode(1'($urandom_range(1)));
        run_random(250, 40);

        s_axis_tvalid <= 1'b0;
        while (expected_lab_q.size() != 0)
            @(posedge clk);
        // Six-stage pipeline; anything extra would show up well within this
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_lab_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
